/* rtl/nae_pkg.sv */
package nae_pkg;

  // Command codes of an input item.
  localparam logic [3:0] CMD_FEAT_W = 4'd0;
  localparam logic [3:0] CMD_FEAT_B = 4'd1;
  localparam logic [3:0] CMD_HID_W  = 4'd2;
  localparam logic [3:0] CMD_HID_B  = 4'd3;
  localparam logic [3:0] CMD_OUT_W  = 4'd4;
  localparam logic [3:0] CMD_OUT_B  = 4'd5;
  localparam logic [3:0] CMD_RESET  = 4'd6;
  localparam logic [3:0] CMD_ADD    = 4'd7;
  localparam logic [3:0] CMD_REMOVE = 4'd8;
  localparam logic [3:0] CMD_EVAL   = 4'd9;

  localparam logic [14:0] EVAL_LIMIT_RESET = 15'd30000;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic [3:0]         command;
    logic               perspective;
    logic [21:0]        address;
    logic signed [31:0] value;
    logic               bad;
  } nae_item_t;

  // Saturates a 32-bit value to a 16-bit weight.
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* rtl/nnue_accumulator_evaluator.sv */
// NNUE evaluator with two perspective accumulators in Q.FRAC_BITS fixed point.
// Items enter a two-entry queue and are executed one at a time. Reset, add
// and remove walk the ACC_SIZE words of one accumulator at one word per cycle
// through the read and the write port of the accumulator memory. Evaluate
// runs over the HID_NODES hidden nodes, one hidden-weight product per cycle;
// the output-weight products use a second multiplier. After reset both
// accumulators are cleared before the first item runs; items may be queued
// during that time and the eval_limit register may be written at any time.
module nnue_accumulator_evaluator #(
  parameter int FEATURES  = 16384,
  parameter int ACC_SIZE  = 256,
  parameter int HID_NODES = 32,
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         command,
  input  logic               perspective,
  input  logic [21:0]        address,
  input  logic signed [31:0] weight_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] score,
  output logic               status,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_data
);
  import nae_pkg::*;

  logic      q_valid;
  logic      q_pop;
  nae_item_t q_item;

  nae_front #(
    .FEATURES  (FEATURES),
    .ACC_SIZE  (ACC_SIZE),
    .HID_NODES (HID_NODES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .perspective  (perspective),
    .address      (address),
    .weight_value (weight_value),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  nae_back #(
    .FEATURES  (FEATURES),
    .ACC_SIZE  (ACC_SIZE),
    .HID_NODES (HID_NODES),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .score     (score),
    .status    (status)
  );

endmodule

/* rtl/nae_front.sv */
module nae_front #(
  parameter int FEATURES  = 16384,
  parameter int ACC_SIZE  = 256,
  parameter int HID_NODES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        command,
  input  logic              perspective,
  input  logic [21:0]       address,
  input  logic signed [31:0] weight_value,
  output logic              q_valid,
  output nae_pkg::nae_item_t q_item,
  input  logic              q_pop
);
  import nae_pkg::*;

  localparam int FW_DEPTH = FEATURES * ACC_SIZE;
  localparam int HW_DEPTH = HID_NODES * 2 * ACC_SIZE;

  logic [31:0] a32;
  logic        bad;
  nae_item_t   item;
  nae_item_t   slot [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;
  logic        push;

  // Classify the item: range check of the address for its command.
  assign a32 = {10'b0, address};
  always_comb begin
    case (command)
      CMD_FEAT_W: bad = (a32 >= 32'(FW_DEPTH));
      CMD_FEAT_B: bad = (a32 >= 32'(ACC_SIZE));
      CMD_HID_W:  bad = (a32 >= 32'(HW_DEPTH));
      CMD_HID_B:  bad = (a32 >= 32'(HID_NODES));
      CMD_OUT_W:  bad = (a32 >= 32'(HID_NODES));
      CMD_OUT_B:  bad = (address != 22'd0);
      CMD_ADD:    bad = (a32 >= 32'(FEATURES));
      CMD_REMOVE: bad = (a32 >= 32'(FEATURES));
      default:    bad = 1'b0;
    endcase
  end

  always_comb begin
    item.command     = command;
    item.perspective = perspective;
    item.address     = address;
    item.value       = weight_value;
    item.bad         = bad;
  end

  // Two-entry queue toward the execution side.
  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !q_pop) |=> (cnt == 2'd2))
    else $error("queue count lost an item");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");

endmodule

/* rtl/nae_back.sv */
module nae_back #(
  parameter int FEATURES  = 16384,
  parameter int ACC_SIZE  = 256,
  parameter int HID_NODES = 32,
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  nae_pkg::nae_item_t q_item,
  output logic               q_pop,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] score,
  output logic               status
);
  import nae_pkg::*;

  localparam int FW_DEPTH = FEATURES * ACC_SIZE;
  localparam int HW_DEPTH = HID_NODES * 2 * ACC_SIZE;
  localparam int AM_DEPTH = 2 * ACC_SIZE;
  localparam int FW_AW    = (FW_DEPTH > 1) ? $clog2(FW_DEPTH) : 1;
  localparam int HW_AW    = (HW_DEPTH > 1) ? $clog2(HW_DEPTH) : 1;
  localparam int ACC_AW   = (ACC_SIZE > 1) ? $clog2(ACC_SIZE) : 1;
  localparam int H_AW     = (HID_NODES > 1) ? $clog2(HID_NODES) : 1;
  localparam int AM_AW    = $clog2(AM_DEPTH);
  localparam int X_W      = FRAC_BITS + 1;
  localparam int ONE      = 1 << FRAC_BITS;

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_WALK    = 4'd2;
  localparam logic [3:0] ST_ROWSET  = 4'd3;
  localparam logic [3:0] ST_ROWINIT = 4'd4;
  localparam logic [3:0] ST_ROW     = 4'd5;
  localparam logic [3:0] ST_HID     = 4'd6;
  localparam logic [3:0] ST_OMUL    = 4'd7;
  localparam logic [3:0] ST_OADD    = 4'd8;
  localparam logic [3:0] ST_FINAL   = 4'd9;

  // Stores.
  logic signed [15:0] fw_mem  [FW_DEPTH];
  logic signed [31:0] fb_mem  [ACC_SIZE];
  logic signed [15:0] hw_mem  [HW_DEPTH];
  logic signed [31:0] hb_mem  [HID_NODES];
  logic signed [31:0] ow_mem  [HID_NODES];
  logic signed [31:0] acc_mem [AM_DEPTH];

  logic signed [15:0] fw_q;
  logic signed [31:0] fb_q;
  logic signed [15:0] hw_q;
  logic signed [31:0] hb_q;
  logic signed [31:0] ow_q;
  logic signed [31:0] acc_q;

  // Control and working registers.
  logic [3:0]          state;
  logic [3:0]          cmd;
  logic                persp;
  logic [ACC_AW-1:0]   n;
  logic                half;
  logic [H_AW-1:0]     h;
  logic [FW_AW-1:0]    fw_ptr;
  logic [HW_AW-1:0]    hw_ptr;
  logic [AM_AW-1:0]    clr_ptr;
  logic [AM_AW-1:0]    wa1;
  logic                iss;
  logic                v1;
  logic                v2;
  logic signed [31:0]  obias;
  logic [14:0]         eval_limit;
  logic signed [16+X_W:0] prod;
  logic signed [32+X_W:0] oprod;
  logic signed [63:0]  s;
  logic signed [63:0]  o;
  logic [X_W-1:0]      hid;

  // Combinational helpers.
  logic [31:0]         qa32;
  logic                rd_side;
  logic [AM_AW-1:0]    acc_raddr;
  logic                acc_we;
  logic [AM_AW-1:0]    acc_waddr;
  logic signed [31:0]  acc_wdata;
  logic signed [32:0]  acc_sum;
  logic [X_W-1:0]      x;
  logic [X_W-1:0]      hid_next;
  logic [63:0]         s_round;
  logic [63:0]         mag;
  logic [63:0]         mag_r;
  logic [15:0]         mag_c;
  logic                out_free;
  logic                out_load;
  logic signed [15:0]  score_next;
  logic                status_next;
  logic                ld;
  logic                last_n;
  logic [31:0]         fw_base;

  assign qa32     = {10'b0, q_item.address};
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == ST_IDLE) && q_valid && out_free;
  assign ld       = q_pop && !q_item.bad;
  assign last_n   = (n == ACC_AW'(ACC_SIZE - 1));
  assign fw_base  = qa32 * 32'(ACC_SIZE);

  // Accumulator read address: the opponent half of the input uses the other side.
  assign rd_side   = (state == ST_ROW) ? (persp ^ half) : persp;
  assign acc_raddr = rd_side ? (AM_AW'(ACC_SIZE) + AM_AW'(n)) : AM_AW'(n);

  // Saturating add or remove of one weight.
  always_comb begin
    if (cmd == CMD_ADD) begin
      acc_sum = {acc_q[31], acc_q} + 33'(fw_q);
    end else begin
      acc_sum = {acc_q[31], acc_q} - 33'(fw_q);
    end
  end

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = wa1;
    acc_wdata = 32'sd0;
    if (state == ST_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_ptr;
    end else if (state == ST_WALK && v1) begin
      acc_we = 1'b1;
      if (cmd == CMD_RESET) begin
        acc_wdata = fb_q;
      end else if (acc_sum[32] != acc_sum[31]) begin
        acc_wdata = acc_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        acc_wdata = acc_sum[31:0];
      end
    end
  end

  // Clipped accumulator input in [0, ONE].
  always_comb begin
    if (acc_q[31]) begin
      x = '0;
    end else if (acc_q > 32'sd0 + 32'(ONE)) begin
      x = X_W'(ONE);
    end else begin
      x = acc_q[X_W-1:0];
    end
  end

  // Hidden activation: round, then clip to [0, ONE].
  always_comb begin
    s_round = 64'(s) + (64'd1 << (FRAC_BITS - 1));
    s_round = s_round >> FRAC_BITS;
    if (s <= 64'sd0) begin
      hid_next = '0;
    end else if (s_round > 64'(ONE)) begin
      hid_next = X_W'(ONE);
    end else begin
      hid_next = s_round[X_W-1:0];
    end
  end

  // Final score: round half away from zero, clamp to the limit.
  always_comb begin
    mag   = o[63] ? 64'(-o) : 64'(o);
    mag_r = (mag + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
    if (mag_r > 64'(eval_limit)) begin
      mag_c = {1'b0, eval_limit};
    end else begin
      mag_c = mag_r[15:0];
    end
  end

  // Store ports: one write (a load, or clear and walk) and one registered read.
  always_ff @(posedge clk) begin
    if (ld && q_item.command == CMD_FEAT_W) begin
      fw_mem[qa32[FW_AW-1:0]] <= sat16(q_item.value);
    end
    fw_q <= fw_mem[fw_ptr];
  end

  always_ff @(posedge clk) begin
    if (ld && q_item.command == CMD_FEAT_B) begin
      fb_mem[qa32[ACC_AW-1:0]] <= q_item.value;
    end
    fb_q <= fb_mem[n];
  end

  always_ff @(posedge clk) begin
    if (ld && q_item.command == CMD_HID_W) begin
      hw_mem[qa32[HW_AW-1:0]] <= sat16(q_item.value);
    end
    hw_q <= hw_mem[hw_ptr];
  end

  always_ff @(posedge clk) begin
    if (ld && q_item.command == CMD_HID_B) begin
      hb_mem[qa32[H_AW-1:0]] <= q_item.value;
    end
    hb_q <= hb_mem[h];
  end

  always_ff @(posedge clk) begin
    if (ld && q_item.command == CMD_OUT_W) begin
      ow_mem[qa32[H_AW-1:0]] <= q_item.value;
    end
    ow_q <= ow_mem[h];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_q <= acc_mem[acc_raddr];
  end

  // Datapath registers of the evaluation.
  always_ff @(posedge clk) begin
    wa1   <= acc_raddr;
    prod  <= hw_q * $signed({1'b0, x});
    oprod <= ow_q * $signed({1'b0, hid});
    if (state == ST_ROWINIT) begin
      s <= 64'(hb_q) <<< FRAC_BITS;
    end else if (v2) begin
      s <= s + 64'(prod);
    end
    if (state == ST_HID) begin
      hid <= hid_next;
    end
    if (q_pop && q_item.command == CMD_EVAL) begin
      o <= 64'(obias) <<< FRAC_BITS;
    end else if (state == ST_OADD) begin
      o <= o + 64'(oprod);
    end
    if (q_pop) begin
      cmd   <= q_item.command;
      persp <= q_item.perspective;
    end
  end

  // Result of the command that finishes in this cycle.
  always_comb begin
    out_load    = 1'b0;
    score_next  = 16'sd0;
    status_next = 1'b0;
    if (q_pop) begin
      status_next = q_item.bad;
      out_load = q_item.bad || !(q_item.command == CMD_RESET || q_item.command == CMD_ADD ||
                                 q_item.command == CMD_REMOVE || q_item.command == CMD_EVAL);
    end else if (state == ST_WALK && !iss && !v1) begin
      out_load = 1'b1;
    end else if (state == ST_FINAL) begin
      out_load   = 1'b1;
      score_next = o[63] ? -$signed(mag_c) : $signed(mag_c);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_ptr    <= '0;
      iss        <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      out_valid  <= 1'b0;
      obias      <= 32'sd0;
      eval_limit <= EVAL_LIMIT_RESET;
      n          <= '0;
      half       <= 1'b0;
      h          <= '0;
      fw_ptr     <= '0;
      hw_ptr     <= '0;
    end else begin
      v1 <= iss;
      v2 <= v1 && (state == ST_ROW);
      if (cfg_we) begin
        eval_limit <= cfg_data;
      end
      if (ld && q_item.command == CMD_OUT_B) begin
        obias <= q_item.value;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        score     <= score_next;
        status    <= status_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == AM_AW'(AM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (ld) begin
            case (q_item.command)
              CMD_RESET, CMD_ADD, CMD_REMOVE: begin
                state  <= ST_WALK;
                n      <= '0;
                iss    <= 1'b1;
                fw_ptr <= fw_base[FW_AW-1:0];
              end
              CMD_EVAL: begin
                state  <= ST_ROWSET;
                h      <= '0;
                hw_ptr <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (iss) begin
            n      <= n + 1'b1;
            fw_ptr <= fw_ptr + 1'b1;
            if (last_n) begin
              iss <= 1'b0;
            end
          end else if (!v1) begin
            state <= ST_IDLE;
          end
        end
        ST_ROWSET: begin
          state <= ST_ROWINIT;
        end
        ST_ROWINIT: begin
          state <= ST_ROW;
          n     <= '0;
          half  <= 1'b0;
          iss   <= 1'b1;
        end
        ST_ROW: begin
          if (iss) begin
            hw_ptr <= hw_ptr + 1'b1;
            if (last_n) begin
              n    <= '0;
              half <= 1'b1;
              if (half) begin
                iss <= 1'b0;
              end
            end else begin
              n <= n + 1'b1;
            end
          end else if (!v1 && !v2) begin
            state <= ST_HID;
          end
        end
        ST_HID: begin
          state <= ST_OMUL;
        end
        ST_OMUL: begin
          state <= ST_OADD;
        end
        ST_OADD: begin
          if (h == H_AW'(HID_NODES - 1)) begin
            state <= ST_FINAL;
          end else begin
            h     <= h + 1'b1;
            state <= ST_ROWSET;
          end
        end
        ST_FINAL: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst) q_pop |-> (state == ST_IDLE))
    else $error("item taken while a command is running");
  a_load_free: assert property (@(posedge clk) disable iff (rst) out_load |-> out_free)
    else $error("result register overwritten");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (score == 16'sd0))
    else $error("rejected item carries a score");
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && !iss && !v1) |=> (state == ST_IDLE && out_valid))
    else $error("accumulator walk ended without a result");

endmodule
